[design/mpp_pkg.sv]
// Package for the monochrome pixel page packer.
// Holds sizes, register codes and the structs shared by the packer modules.
`default_nettype none

package mpp_pkg;

  // Column buffer depth
  localparam int MAX_COLUMNS = 256;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  // Width for column compares: holds the column count and a position plus one
  localparam int CMP_W       = (COL_W + 1 > 9) ? COL_W + 1 : 9;

  // Configuration port
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_CNT_W   = 9;
  localparam int PAGE_CNT_W  = 4;
  localparam int COL_CNT_RST  = 256;
  localparam int PAGE_CNT_RST = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = CFG_IDX_W'(1);

  // Buffer word: written-bits mask above the column byte
  localparam int WORD_W = 16;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [2:0]       row;
    logic [2:0]       page;
    logic             row_end;
    logic             page_end;
  } pos_t;

  typedef struct packed {
    logic [7:0] page_byte;
    logic [7:0] column_offset;
    logic [2:0] page_offset;
    logic       last_of_page;
    logic       last_of_area;
  } item_t;

endpackage

`default_nettype wire

[design/mpp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents when read and write hit the same address.
`default_nettype none

module mpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire [$clog2(DEPTH)-1:0]     waddr_i,
  input  wire [WIDTH-1:0]             wdata_i,
  input  wire                         re_i,
  input  wire [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/mpp_seq.sv]
// Position sequencer: configuration registers and column/row/page counters.
// Depends on mpp_pkg.
`default_nettype none

module mpp_seq (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [mpp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [mpp_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire                             accept_i,
  input  wire                             first_i,
  output mpp_pkg::pos_t                   pos_o
);
  import mpp_pkg::*;

  logic [COL_CNT_W-1:0]  col_cnt_q;
  logic [PAGE_CNT_W-1:0] page_cnt_q;
  logic [COL_W-1:0]      col_q, col_d;
  logic [2:0]            row_q, row_d;
  logic [2:0]            page_q, page_d;

  logic [CMP_W-1:0]      cols_raw, cols_eff;
  logic [PAGE_CNT_W-1:0] pages_eff;
  pos_t                  pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= COL_CNT_W'(COL_CNT_RST);
      page_cnt_q <= PAGE_CNT_W'(PAGE_CNT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COLUMN_COUNT: col_cnt_q  <= cfg_data_i[COL_CNT_W-1:0];
        REG_PAGE_COUNT:   page_cnt_q <= cfg_data_i[PAGE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configured counts into their usable ranges
  always_comb begin
    cols_raw = CMP_W'(col_cnt_q);
    priority if (cols_raw == '0) begin
      cols_eff = CMP_W'(1);
    end else if (cols_raw > CMP_W'(MAX_COLUMNS)) begin
      cols_eff = CMP_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_raw;
    end
    priority if (page_cnt_q == '0) begin
      pages_eff = PAGE_CNT_W'(1);
    end else if (page_cnt_q > PAGE_CNT_W'(8)) begin
      pages_eff = PAGE_CNT_W'(8);
    end else begin
      pages_eff = page_cnt_q;
    end
  end

  always_comb begin
    // A new area restarts from the origin
    pos.col      = first_i ? '0 : col_q;
    pos.row      = first_i ? '0 : row_q;
    pos.page     = first_i ? '0 : page_q;
    pos.row_end  = (CMP_W'(pos.col) + CMP_W'(1)) >= cols_eff;
    pos.page_end = (PAGE_CNT_W'(pos.page) + PAGE_CNT_W'(1)) >= pages_eff;
    pos_o        = pos;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    page_d = page_q;
    if (accept_i) begin
      if (pos.row_end) begin
        col_d = '0;
        if (pos.row == 3'd7) begin
          row_d  = '0;
          page_d = pos.page_end ? 3'd0 : pos.page + 3'd1;
        end else begin
          row_d  = pos.row + 3'd1;
          page_d = pos.page;
        end
      end else begin
        col_d  = pos.col + COL_W'(1);
        row_d  = pos.row;
        page_d = pos.page;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      page_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      page_q <= page_d;
    end
  end

endmodule

`default_nettype wire

[design/mpp_outq.sv]
// Two-entry result queue between the write-back stage and the output port.
// Depends on mpp_pkg.
`default_nettype none

module mpp_outq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire mpp_pkg::item_t  item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output mpp_pkg::item_t       item_o,
  output logic [1:0]           count_o,
  output logic                 pop_o
);
  import mpp_pkg::*;

  item_t      ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign item_o      = ent_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign pop_o       = pop;
  assign count_o     = cnt_q;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/mono_pixel_page_packer_top.sv]
// Top level of the monochrome pixel page packer: column buffer RAM, read-modify-write
// stage with forwarding, position sequencer and result queue. Depends on mpp_pkg.
`default_nettype none

// Takes one pixel per cycle in row-major order and emits one byte per column at the
// eighth row of each page, top row in bit 0. Each column entry of the buffer RAM keeps
// the byte and an eight-bit mask of rows written; a byte goes out only once all eight
// rows of it were written. An accepted pixel reads its column entry in the accept
// cycle and writes it back in the next; back-to-back hits on one column are forwarded
// from the last write. After reset the buffer is cleared one entry per cycle, over
// all MAX_COLUMNS (256) entries, during which in_stall_o stays high; configuration
// writes are taken throughout. Beyond that, in_stall_o rises only while the result
// queue and the write-back stage together hold more than one request (more than two
// when a result leaves in the same cycle), so a receiver that keeps up sees one pixel
// taken every cycle.
module mono_pixel_page_packer_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [mpp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [mpp_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           pixel_white_i,
  input  wire                           first_of_area_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [7:0]                    page_byte_o,
  output logic [7:0]                    column_offset_o,
  output logic [2:0]                    page_offset_o,
  output logic                          last_of_page_o,
  output logic                          last_of_area_o
);
  import mpp_pkg::*;

  logic              accept;
  pos_t              pos;

  // clearing pass
  logic              clr_q;
  logic [COL_W-1:0]  clr_addr_q;

  // write-back stage
  logic              s1_valid_q;
  pos_t              s1_pos_q;
  logic              s1_white_q;

  // last write, for forwarding
  logic              fwd_valid_q;
  logic [COL_W-1:0]  fwd_addr_q;
  logic [WORD_W-1:0] fwd_data_q;

  logic [WORD_W-1:0] rdata, cur_word, wb_word;
  logic [7:0]        bit_sel, new_byte, new_mask;
  logic              emit;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  item_t             push_item, out_item;
  logic              push;
  logic [1:0]        q_count;
  logic              q_pop;
  logic [2:0]        occ;

  mpp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .first_i     (first_of_area_i),
    .pos_o       (pos)
  );

  // Hold input while the queue could overflow with what is in flight
  assign occ        = 3'(q_count) + 3'(s1_valid_q);
  assign in_stall_o = clr_q || (occ > (q_pop ? 3'd2 : 3'd1));
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + COL_W'(1);
      if (clr_addr_q == COL_W'(MAX_COLUMNS - 1)) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q   <= pos;
      s1_white_q <= pixel_white_i;
    end
  end

  // Modify the column entry
  always_comb begin
    cur_word = (fwd_valid_q && fwd_addr_q == s1_pos_q.col) ? fwd_data_q : rdata;
    bit_sel  = 8'd1 << s1_pos_q.row;
    new_byte = s1_white_q ? (cur_word[7:0] & ~bit_sel) : (cur_word[7:0] | bit_sel);
    new_mask = cur_word[15:8] | bit_sel;
    emit     = (s1_pos_q.row == 3'd7) && (new_mask == 8'hFF);
    // Emitting drops the mask so the next page starts empty
    wb_word  = {(emit ? 8'h00 : new_mask), new_byte};
  end

  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_q;
      ram_waddr = s1_pos_q.col;
      ram_wdata = wb_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_valid_q) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fwd_addr_q <= s1_pos_q.col;
      fwd_data_q <= wb_word;
    end
  end

  mpp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_COLUMNS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (pos.col),
    .rdata_o (rdata)
  );

  always_comb begin
    push                    = s1_valid_q && emit;
    push_item.page_byte     = new_byte;
    push_item.column_offset = 8'(s1_pos_q.col);
    push_item.page_offset   = s1_pos_q.page;
    push_item.last_of_page  = s1_pos_q.row_end;
    push_item.last_of_area  = s1_pos_q.row_end && s1_pos_q.page_end;
  end

  mpp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (out_item),
    .count_o     (q_count),
    .pop_o       (q_pop)
  );

  assign page_byte_o     = out_item.page_byte;
  assign column_offset_o = out_item.column_offset;
  assign page_offset_o   = out_item.page_offset;
  assign last_of_page_o  = out_item.last_of_page;
  assign last_of_area_o  = out_item.last_of_area;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for mono_pixel_page_packer_top: drives pixel requests and register writes,
// predicts every emitted column byte and checks it. Depends on mpp_pkg and the RTL.

module testbench;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PIXELS = 300;
  localparam int HOLD_CYCLES   = 800;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_COLS      = mpp_pkg::MAX_COLUMNS;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [mpp_pkg::CFG_IDX_W-1:0] cfg_index_i     = mpp_pkg::REG_COLUMN_COUNT;
  logic [mpp_pkg::CFG_W-1:0]     cfg_data_i      = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          pixel_white_i   = 1'b0;
  logic                          first_of_area_i = 1'b0;
  logic                          out_stall_i     = 1'b1;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic [7:0]                    page_byte_o;
  logic [7:0]                    column_offset_o;
  logic [2:0]                    page_offset_o;
  logic                          last_of_page_o;
  logic                          last_of_area_o;

  mono_pixel_page_packer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_white_i   (pixel_white_i),
    .first_of_area_i (first_of_area_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .page_byte_o     (page_byte_o),
    .column_offset_o (column_offset_o),
    .page_offset_o   (page_offset_o),
    .last_of_page_o  (last_of_page_o),
    .last_of_area_o  (last_of_area_o)
  );

  always #2 clk_i = ~clk_i;

  // Packer model state
  logic [8:0]      column_count_q = 9'd256;
  logic [3:0]      page_count_q   = 4'd8;
  logic [7:0]      col_byte [MAX_COLS];
  logic [7:0]      rows_written [MAX_COLS];
  int unsigned     col_pos, row_pos, page_pos;
  mpp_pkg::item_t  pending_bytes[$];

  int  error_count  = 0;
  int  pixels_sent  = 0;
  int  cycle_count  = 0;
  bit  burst_mode   = 1'b0;
  int  hold_req     = 0;
  int  hold_served  = 0;
  int  hold_left    = 0;
  int  stall_run    = 0;
  bit  stall_on     = 1'b1;

  initial begin
    for (int c = 0; c < MAX_COLS; c++) rows_written[c] = 8'h00;
    col_pos  = 0;
    row_pos  = 0;
    page_pos = 0;
  end

  function automatic int unsigned active_columns();
    if (column_count_q == 0) return 1;
    if (column_count_q > MAX_COLS) return MAX_COLS;
    return column_count_q;
  endfunction

  function automatic int unsigned active_pages();
    if (page_count_q == 0) return 1;
    if (page_count_q > 8) return 8;
    return page_count_q;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Place one pixel into its column byte and queue the byte once the column is complete.
  task automatic pack_pixel(input logic white, input logic first);
    int unsigned    cols, pages, col;
    logic [2:0]     row, page;
    logic           row_end, page_end;
    mpp_pkg::item_t done;
    cols  = active_columns();
    pages = active_pages();
    if (first) begin
      col_pos  = 0;
      row_pos  = 0;
      page_pos = 0;
    end
    col  = col_pos % MAX_COLS;
    row  = row_pos[2:0];
    page = page_pos[2:0];
    col_byte[col][row]     = ~white;
    rows_written[col][row] = 1'b1;
    row_end  = (col + 1) >= cols;
    page_end = (page + 1) >= pages;
    if (row == 3'd7 && rows_written[col] == 8'hFF) begin
      done.page_byte     = col_byte[col];
      done.column_offset = col[7:0];
      done.page_offset   = page;
      done.last_of_page  = row_end;
      done.last_of_area  = row_end && page_end;
      pending_bytes.push_back(done);
      rows_written[col] = 8'h00;
    end
    if (row_end) begin
      col_pos = 0;
      if (row == 3'd7) begin
        row_pos  = 0;
        page_pos = page_end ? 0 : page + 1;
      end else begin
        row_pos = row + 1;
      end
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic send_pixel(input logic white, input logic first);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    pixel_white_i   <= white;
    first_of_area_i <= first;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pack_pixel(white, first);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [mpp_pkg::CFG_IDX_W-1:0] index,
                           input logic [mpp_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (index == mpp_pkg::REG_COLUMN_COUNT) column_count_q = value[8:0];
    else if (index == mpp_pkg::REG_PAGE_COUNT) page_count_q = value[3:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every queued byte, then let the pipeline drain.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // Reset settings first; these pixels wait out the buffer clear.
    send_pixel(1'b0, 1'b1);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    settle();
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'd2);
    write_reg(mpp_pkg::REG_PAGE_COUNT, 9'd1);
    for (int row = 0; row < 8; row++) begin
      send_pixel(1'b0, row == 0);
      send_pixel(1'b1, 1'b0);
    end
    settle();
    // Zero counts act as one column and one page.
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'd0);
    write_reg(mpp_pkg::REG_PAGE_COUNT, 9'd0);
    for (int row = 0; row < 8; row++) send_pixel(row % 2 == 0, row == 0);
  endtask

  task automatic test_column_extremes();
    settle();
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'd256);
    write_reg(mpp_pkg::REG_PAGE_COUNT, 9'd8);
    for (int i = 0; i < 300; i++) send_pixel(1'($urandom_range(0, 1)), i == 0);
    settle();
    // Out-of-range counts saturate.
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'h1FF);
    write_reg(mpp_pkg::REG_PAGE_COUNT, 9'hF);
    for (int i = 0; i < 120; i++) send_pixel(1'($urandom_range(0, 1)), 1'b0);
    settle();
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'd5);
    for (int i = 0; i < 60; i++) send_pixel(1'($urandom_range(0, 1)), 1'b0);
    settle();
    // Shrink the row while the eighth row is partly done (ten of its twelve pixels sent).
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'd12);
    write_reg(mpp_pkg::REG_PAGE_COUNT, 9'd1);
    for (int i = 0; i < 7 * 12 + 10; i++) send_pixel(1'($urandom_range(0, 1)), i == 0);
    settle();
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'd4);
    for (int i = 0; i < 9; i++) send_pixel(1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(mpp_pkg::REG_COLUMN_COUNT, 9'd2);
    write_reg(mpp_pkg::REG_PAGE_COUNT, 9'd8);
    burst_mode = 1'b1;
    hold_req++;
    for (int i = 0; i < 160; i++) send_pixel(1'($urandom_range(0, 1)), i == 0);
    burst_mode = 1'b0;
  endtask

  task automatic test_random_areas();
    int          start, area, count, kind, r, white_mode;
    bit          use_first;
    logic [8:0]  cols;
    logic [8:0]  pages;
    logic        white, first;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      settle();
      burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 5) cols = 9'd0;
      else if (r < 70) cols = 9'($urandom_range(1, 8));
      else if (r < 92) cols = 9'($urandom_range(9, 24));
      else cols = 9'($urandom_range(25, 48));
      r = $urandom_range(0, 99);
      if (r < 5) pages = 9'd0;
      else if (r < 10) pages = 9'($urandom_range(9, 15));
      else if (r < 70) pages = 9'($urandom_range(1, 3));
      else pages = 9'($urandom_range(4, 8));
      r = $urandom_range(0, 9);
      if (r < 8 || r == 8) write_reg(mpp_pkg::REG_COLUMN_COUNT, cols);
      if (r < 8 || r == 9) write_reg(mpp_pkg::REG_PAGE_COUNT, pages);
      area       = active_columns() * 8 * active_pages();
      use_first  = ($urandom_range(0, 3) != 0);
      white_mode = $urandom_range(0, 9);
      kind       = $urandom_range(0, 99);
      if (kind < 65) begin
        count = area * $urandom_range(1, 2);
        if (count > 200) count = 200;
      end else if (kind < 85) begin
        count = $urandom_range(1, (area < 200) ? area : 200);
      end else begin
        count = $urandom_range(20, 200);
      end
      for (int i = 0; i < count; i++) begin
        if (white_mode == 0) white = 1'b0;
        else if (white_mode == 1) white = 1'b1;
        else white = 1'($urandom_range(0, 1));
        if (kind < 85) first = use_first && (i % area == 0);
        else first = ($urandom_range(0, 15) == 0);
        send_pixel(white, first);
      end
    end
    burst_mode = 1'b0;
  endtask

  // Receiver: random stall runs, plus a long hold on request.
  always @(negedge clk_i) begin
    if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run > 0) begin
        stall_run--;
      end else if (stall_on) begin
        stall_on  = 1'b0;
        stall_run = $urandom_range(0, 30);
      end else begin
        stall_on  = 1'b1;
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
      out_stall_i <= stall_on;
    end
  end

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    mpp_pkg::item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_bytes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected byte %h at column %0d", $time, page_byte_o,
                 column_offset_o);
      end else begin
        want = pending_bytes.pop_front();
        check_field("page_byte", want.page_byte, page_byte_o);
        check_field("column_offset", want.column_offset, column_offset_o);
        check_field("page_offset", 8'(want.page_offset), 8'(page_offset_o));
        check_field("last_of_page", 8'(want.last_of_page), 8'(last_of_page_o));
        check_field("last_of_area", 8'(want.last_of_area), 8'(last_of_area_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_column_extremes();
    test_backpressure();
    test_random_areas();
    settle();
    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
